[hw/rtl/tilpf_pkg.sv]
// shared types and codes for the turn indicator long-press flasher
package tilpf_pkg;

    // widths of the time stamp and the configuration registers
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    // configuration register indexes
    localparam logic CFG_LONG_PRESS   = 1'b0;
    localparam logic CFG_BLINK_PERIOD = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] BLINK_PERIOD_RST = 16'd300;

    // indicator mode, coded as it appears on the result word
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LEFT   = 2'd1,
        MODE_RIGHT  = 2'd2,
        MODE_HAZARD = 2'd3
    } t_mode;

    // one button poll
    typedef struct packed {
        logic              left_pressed;
        logic              right_pressed;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    // one result
    typedef struct packed {
        logic       left_lamp;
        logic       right_lamp;
        logic [1:0] mode;
        logic       hazard_event;
        logic       blink_refresh;
    } t_out_word;

    // flasher state carried from poll to poll
    typedef struct packed {
        t_mode             mode;
        logic [TIME_W-1:0] left_start;
        logic [TIME_W-1:0] right_start;
        logic [TIME_W-1:0] both_start;
        logic              left_fired;
        logic              right_fired;
        logic              both_fired;
        logic              left_held;
        logic              right_held;
        logic [TIME_W-1:0] last_blink;
        logic              blink_phase;
        logic [1:0]        lamps;
    } t_state;

    localparam t_state STATE_RST = '{
        mode:        MODE_IDLE,
        left_start:  '0,
        right_start: '0,
        both_start:  '0,
        left_fired:  1'b0,
        right_fired: 1'b0,
        both_fired:  1'b0,
        left_held:   1'b0,
        right_held:  1'b0,
        last_blink:  '0,
        blink_phase: 1'b0,
        lamps:       2'b00
    };

endpackage

[hw/rtl/turn_indicator_long_press_flasher.sv]
// top level of the turn indicator long-press flasher
//
//   channel   direction  handshake                  word
//   ---------------------------------------------------------------
//   poll      in         i_in_valid / o_in_stall    i_in_word
//   result    out        o_out_valid / i_out_stall  o_out_word
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one poll per cycle unless the result stalls: a poll is registered, then the
// step logic updates the flasher state and the result register from it.
// the step is gated by the result register, so a stalled result holds the
// poll register; one poll is still taken while a result waits.
// synchronous active-low reset clears state, config goes to 1000 ms / 300 ms.
module turn_indicator_long_press_flasher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tilpf_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tilpf_pkg::t_out_word          o_out_word,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tilpf_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                         r_in_vld;
    tilpf_pkg::t_in_word          r_in_word;
    logic                         r_out_vld;
    tilpf_pkg::t_out_word         r_out_word;
    tilpf_pkg::t_state            r_state;
    tilpf_pkg::t_state            n_state;
    tilpf_pkg::t_out_word         n_out_word;
    logic [tilpf_pkg::CFG_W-1:0]  r_long_press_ms;
    logic [tilpf_pkg::CFG_W-1:0]  r_blink_period_ms;
    logic                         step_go;
    logic                         in_take;

    // pipeline control
    assign step_go    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !step_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms   <= tilpf_pkg::LONG_PRESS_RST;
            r_blink_period_ms <= tilpf_pkg::BLINK_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tilpf_pkg::CFG_LONG_PRESS:   r_long_press_ms   <= i_cfg_data;
                tilpf_pkg::CFG_BLINK_PERIOD: r_blink_period_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // poll register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // step logic
    tilpf_step u_step (
        .i_state           (r_state),
        .i_word            (r_in_word),
        .i_long_press_ms   (r_long_press_ms),
        .i_blink_period_ms (r_blink_period_ms),
        .o_state           (n_state),
        .o_word            (n_out_word)
    );

    // flasher state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tilpf_pkg::STATE_RST;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // a hazard event always leaves the block in hazard mode
    a_hazard_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.hazard_event) |->
            (o_out_word.mode == tilpf_pkg::MODE_HAZARD))
        else $error("hazard event without hazard mode");

    // a held poll is not overwritten
    a_poll_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !step_go) |=> (r_in_vld && $stable(r_in_word)))
        else $error("poll register lost a word");

    // lamps change only on a blink refresh
    a_lamps_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!step_go || !n_out_word.blink_refresh) |=> $stable(r_state.lamps))
        else $error("lamps changed without refresh");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

[hw/rtl/tilpf_step.sv]
// combinational update of the flasher state for one poll
module tilpf_step (
    input  tilpf_pkg::t_state                 i_state,
    input  tilpf_pkg::t_in_word               i_word,
    input  logic [tilpf_pkg::CFG_W-1:0]       i_long_press_ms,
    input  logic [tilpf_pkg::CFG_W-1:0]       i_blink_period_ms,
    output tilpf_pkg::t_state                 o_state,
    output tilpf_pkg::t_out_word              o_word
);

    // wrapped elapsed time compared against a 16-bit limit
    function automatic logic elapsed_ge(
        input logic [tilpf_pkg::TIME_W-1:0] cur_ms,
        input logic [tilpf_pkg::TIME_W-1:0] start_ms,
        input logic [tilpf_pkg::CFG_W-1:0]  limit
    );
        logic [tilpf_pkg::TIME_W-1:0] diff;
        diff = cur_ms - start_ms;
        return (diff[tilpf_pkg::TIME_W-1:tilpf_pkg::CFG_W] != '0) ||
               (diff[tilpf_pkg::CFG_W-1:0] >= limit);
    endfunction

    logic                         lt;
    logic                         rt;
    logic [tilpf_pkg::TIME_W-1:0] now_ms;
    logic [tilpf_pkg::TIME_W-1:0] left_start;
    logic [tilpf_pkg::TIME_W-1:0] right_start;
    logic [tilpf_pkg::TIME_W-1:0] both_start;
    logic                         left_fired;
    logic                         right_fired;
    logic                         both_fired;
    logic                         left_fire;
    logic                         right_fire;
    logic                         both_fire;
    logic                         refresh;
    logic                         phase;
    logic [1:0]                   lamps;
    tilpf_pkg::t_mode             mode_l;
    tilpf_pkg::t_mode             mode_r;
    tilpf_pkg::t_mode             mode_h;

    assign lt     = i_word.left_pressed;
    assign rt     = i_word.right_pressed;
    assign now_ms = i_word.now_ms;

    // press start times and fire flags, zero start means not pressed
    always_comb begin
        both_start  = i_state.both_start;
        left_start  = i_state.left_start;
        right_start = i_state.right_start;
        left_fired  = i_state.left_fired;
        right_fired = i_state.right_fired;
        both_fired  = i_state.both_fired;
        if (lt && rt && !(i_state.left_held && i_state.right_held)) begin
            both_start = now_ms;
        end
        if (!lt) begin
            left_fired = 1'b0;
            left_start = '0;
        end
        if (!rt) begin
            right_fired = 1'b0;
            right_start = '0;
        end
        if (!lt || !rt) begin
            both_fired = 1'b0;
            both_start = '0;
        end
        if (lt && (left_start == '0)) begin
            left_start = now_ms;
        end
        if (rt && (right_start == '0)) begin
            right_start = now_ms;
        end
    end

    // long-press detection, each press fires once per hold
    assign left_fire  = lt && !left_fired &&
                        elapsed_ge(now_ms, left_start, i_long_press_ms);
    assign right_fire = rt && !right_fired &&
                        elapsed_ge(now_ms, right_start, i_long_press_ms);
    assign both_fire  = lt && rt && !both_fired &&
                        elapsed_ge(now_ms, both_start, i_long_press_ms);

    // mode update: left, then right, then hazard overrides
    always_comb begin
        mode_l = i_state.mode;
        if (left_fire) begin
            mode_l = ((i_state.mode == tilpf_pkg::MODE_IDLE) ||
                      (i_state.mode == tilpf_pkg::MODE_RIGHT)) ?
                     tilpf_pkg::MODE_LEFT : tilpf_pkg::MODE_IDLE;
        end
        mode_r = mode_l;
        if (right_fire) begin
            mode_r = ((mode_l == tilpf_pkg::MODE_IDLE) ||
                      (mode_l == tilpf_pkg::MODE_LEFT)) ?
                     tilpf_pkg::MODE_RIGHT : tilpf_pkg::MODE_IDLE;
        end
        mode_h = both_fire ? tilpf_pkg::MODE_HAZARD : mode_r;
    end

    // blink phase toggle and lamp refresh
    assign refresh = elapsed_ge(now_ms, i_state.last_blink, i_blink_period_ms);
    assign phase   = i_state.blink_phase ^ refresh;

    always_comb begin
        lamps = i_state.lamps;
        if (refresh) begin
            case (mode_h)
                tilpf_pkg::MODE_LEFT:   lamps = {1'b0, phase};
                tilpf_pkg::MODE_RIGHT:  lamps = {phase, 1'b0};
                tilpf_pkg::MODE_HAZARD: lamps = {phase, phase};
                default:                lamps = 2'b00;
            endcase
        end
    end

    // next state
    always_comb begin
        o_state.mode        = mode_h;
        o_state.left_start  = left_start;
        o_state.right_start = right_start;
        o_state.both_start  = both_start;
        o_state.left_fired  = left_fired || left_fire;
        o_state.right_fired = right_fired || right_fire;
        o_state.both_fired  = both_fired || both_fire;
        o_state.left_held   = lt;
        o_state.right_held  = rt;
        o_state.last_blink  = refresh ? now_ms : i_state.last_blink;
        o_state.blink_phase = phase;
        o_state.lamps       = lamps;
    end

    // result word
    always_comb begin
        o_word.left_lamp     = lamps[0];
        o_word.right_lamp    = lamps[1];
        o_word.mode          = mode_h;
        o_word.hazard_event  = both_fire;
        o_word.blink_refresh = refresh;
    end

endmodule

[sim/turn_indicator_long_press_flasher_tb.sv]
// testbench for the turn indicator flasher: directed and random polls checked by a scoreboard
`timescale 1ns / 100ps

module turn_indicator_long_press_flasher_tb;

    // predicts one result word per accepted poll and compares it with the block
    class flasher_scoreboard;
        logic [tilpf_pkg::CFG_W-1:0]  hold_ms;
        logic [tilpf_pkg::CFG_W-1:0]  period_ms;
        tilpf_pkg::t_mode             cur_mode;
        logic [tilpf_pkg::TIME_W-1:0] left_t0;
        logic [tilpf_pkg::TIME_W-1:0] right_t0;
        logic [tilpf_pkg::TIME_W-1:0] both_t0;
        logic [tilpf_pkg::TIME_W-1:0] blink_t0;
        logic                         left_done;
        logic                         right_done;
        logic                         both_done;
        logic                         prev_lt;
        logic                         prev_rt;
        logic                         phase;
        logic [1:0]                   lamps;
        tilpf_pkg::t_out_word         lamp_words_due[$];
        int unsigned                  results_seen;
        int unsigned                  mismatches;

        function new();
            hold_ms      = tilpf_pkg::LONG_PRESS_RST;
            period_ms    = tilpf_pkg::BLINK_PERIOD_RST;
            cur_mode     = tilpf_pkg::MODE_IDLE;
            left_t0      = '0;
            right_t0     = '0;
            both_t0      = '0;
            blink_t0     = '0;
            left_done    = 1'b0;
            right_done   = 1'b0;
            both_done    = 1'b0;
            prev_lt      = 1'b0;
            prev_rt      = 1'b0;
            phase        = 1'b0;
            lamps        = 2'b00;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic idx, logic [tilpf_pkg::CFG_W-1:0] val);
            if (idx == tilpf_pkg::CFG_LONG_PRESS) begin
                hold_ms = val;
            end else begin
                period_ms = val;
            end
        endfunction

        function int pending();
            return lamp_words_due.size();
        endfunction

        // one flasher step for an accepted poll
        function void note_poll(tilpf_pkg::t_in_word w);
            tilpf_pkg::t_out_word         due;
            logic                         lt;
            logic                         rt;
            logic [tilpf_pkg::TIME_W-1:0] t;
            lt  = w.left_pressed;
            rt  = w.right_pressed;
            t   = w.now_ms;
            due = '0;

            // both-button hold starts on the first poll with both held
            if (lt && rt && !(prev_lt && prev_rt)) begin
                both_t0 = t;
            end
            if (!lt) begin
                left_done = 1'b0;
                left_t0   = '0;
            end
            if (!rt) begin
                right_done = 1'b0;
                right_t0   = '0;
            end
            if (!lt || !rt) begin
                both_done = 1'b0;
                both_t0   = '0;
            end

            // zero start reads as not pressed, so the current time is taken
            if (lt && left_t0 == '0) begin
                left_t0 = t;
            end
            if (rt && right_t0 == '0) begin
                right_t0 = t;
            end

            // single-button long presses, left first
            if (lt && (t - left_t0) >= hold_ms && !left_done) begin
                left_done = 1'b1;
                if (cur_mode == tilpf_pkg::MODE_IDLE || cur_mode == tilpf_pkg::MODE_RIGHT) begin
                    cur_mode = tilpf_pkg::MODE_LEFT;
                end else begin
                    cur_mode = tilpf_pkg::MODE_IDLE;
                end
            end
            if (rt && (t - right_t0) >= hold_ms && !right_done) begin
                right_done = 1'b1;
                if (cur_mode == tilpf_pkg::MODE_IDLE || cur_mode == tilpf_pkg::MODE_LEFT) begin
                    cur_mode = tilpf_pkg::MODE_RIGHT;
                end else begin
                    cur_mode = tilpf_pkg::MODE_IDLE;
                end
            end

            // hazard is judged last and overrides
            if (lt && rt && (t - both_t0) >= hold_ms && !both_done) begin
                both_done        = 1'b1;
                cur_mode         = tilpf_pkg::MODE_HAZARD;
                due.hazard_event = 1'b1;
            end
            prev_lt = lt;
            prev_rt = rt;

            // blink phase toggle and lamp rewrite
            if ((t - blink_t0) >= period_ms) begin
                blink_t0          = t;
                phase             = ~phase;
                due.blink_refresh = 1'b1;
                case (cur_mode)
                    tilpf_pkg::MODE_LEFT: begin
                        lamps = {1'b0, phase};
                    end
                    tilpf_pkg::MODE_RIGHT: begin
                        lamps = {phase, 1'b0};
                    end
                    tilpf_pkg::MODE_HAZARD: begin
                        lamps = {phase, phase};
                    end
                    default: begin
                        lamps = 2'b00;
                    end
                endcase
            end

            due.left_lamp  = lamps[0];
            due.right_lamp = lamps[1];
            due.mode       = cur_mode;
            lamp_words_due.push_back(due);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // compare one accepted result word with the oldest prediction
        task check_result(tilpf_pkg::t_out_word got);
            tilpf_pkg::t_out_word due;
            results_seen++;
            if (lamp_words_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with no poll outstanding", results_seen));
                return;
            end
            due = lamp_words_due.pop_front();
            if (got.left_lamp !== due.left_lamp) begin
                report_mismatch($sformatf("result %0d left_lamp %b, want %b",
                                          results_seen, got.left_lamp, due.left_lamp));
            end
            if (got.right_lamp !== due.right_lamp) begin
                report_mismatch($sformatf("result %0d right_lamp %b, want %b",
                                          results_seen, got.right_lamp, due.right_lamp));
            end
            if (got.mode !== due.mode) begin
                report_mismatch($sformatf("result %0d mode %0d, want %0d",
                                          results_seen, got.mode, due.mode));
            end
            if (got.hazard_event !== due.hazard_event) begin
                report_mismatch($sformatf("result %0d hazard_event %b, want %b",
                                          results_seen, got.hazard_event, due.hazard_event));
            end
            if (got.blink_refresh !== due.blink_refresh) begin
                report_mismatch($sformatf("result %0d blink_refresh %b, want %b",
                                          results_seen, got.blink_refresh, due.blink_refresh));
            end
        endtask
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    tilpf_pkg::t_in_word          i_in_word   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    tilpf_pkg::t_out_word         o_out_word;
    logic                         i_cfg_we    = 1'b0;
    logic                         i_cfg_idx   = 1'b0;
    logic [tilpf_pkg::CFG_W-1:0]  i_cfg_data  = '0;

    flasher_scoreboard            sb = new();
    logic                         calm = 1'b0;
    logic [tilpf_pkg::TIME_W-1:0] clock_ms = '0;

    turn_indicator_long_press_flasher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_word);
        end
    end

    // receiver stalls in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // send one poll word, with an occasional gap before it
    task automatic send_poll(input logic lt, input logic rt,
                             input logic [tilpf_pkg::TIME_W-1:0] t);
        tilpf_pkg::t_in_word w;
        w.left_pressed  = lt;
        w.right_pressed = rt;
        w.now_ms        = t;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_poll(w);
    endtask

    // register write once every outstanding result is back
    task automatic write_reg(input logic idx, input logic [tilpf_pkg::CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // mostly forward, sometimes backward time steps
    function automatic void advance_clock(input int unsigned max_step);
        if ($urandom_range(0, 19) == 0) begin
            clock_ms -= $urandom_range(0, max_step);
        end else begin
            clock_ms += $urandom_range(0, max_step);
        end
    endfunction

    // button hold sequences with random content, plus some noise polls
    task automatic run_traffic(input int n_items, input int unsigned max_step);
        int   sent;
        int   len;
        int   kind;
        int   k;
        int   lead;
        logic lt;
        logic rt;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
                sent++;
            end else begin
                len  = $urandom_range(1, 24);
                lead = $urandom_range(0, 1);
                for (k = 0; k < len; k++) begin
                    case (kind % 4)
                        0: begin
                            lt = 1'b1;
                            rt = 1'b1;
                        end
                        1: begin
                            lt = 1'b1;
                            rt = 1'b0;
                        end
                        2: begin
                            lt = 1'b0;
                            rt = 1'b1;
                        end
                        default: begin
                            // one side first, the other joins half way
                            lt = (lead == 0) || (k >= len / 2);
                            rt = (lead == 1) || (k >= len / 2);
                        end
                    endcase
                    // occasional bounce breaks the hold
                    if ($urandom_range(0, 19) == 0) begin
                        if ($urandom_range(0, 1) == 0) begin
                            lt = ~lt;
                        end else begin
                            rt = ~rt;
                        end
                    end
                    advance_clock(max_step);
                    send_poll(lt, rt, clock_ms);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    advance_clock(max_step);
                    send_poll(1'b0, 1'b0, clock_ms);
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        int                          p;
        logic [tilpf_pkg::CFG_W-1:0] hold;
        logic [tilpf_pkg::CFG_W-1:0] period;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // press at time zero, then the start is taken from the next poll
        send_poll(1'b1, 1'b0, 32'd0);
        send_poll(1'b1, 1'b0, 32'd5);
        send_poll(1'b1, 1'b0, 32'd1005);
        send_poll(1'b0, 1'b0, 32'd1100);
        // right long press from left
        send_poll(1'b0, 1'b1, 32'd1200);
        send_poll(1'b0, 1'b1, 32'd2200);
        send_poll(1'b0, 1'b0, 32'd2300);
        // both together: singles fire, then hazard overrides
        send_poll(1'b1, 1'b1, 32'd2400);
        send_poll(1'b1, 1'b1, 32'd3400);
        send_poll(1'b0, 1'b0, 32'd3500);
        // right long press leaves hazard
        send_poll(1'b0, 1'b1, 32'd3600);
        send_poll(1'b0, 1'b1, 32'd4600);
        // left first, then both
        send_poll(1'b1, 1'b0, 32'd4700);
        send_poll(1'b1, 1'b1, 32'd4800);
        send_poll(1'b1, 1'b1, 32'd5800);
        // all-ones time and a hold across the wrap
        send_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 1'b1, 32'hFFFF_FFFF);
        send_poll(1'b1, 1'b1, 32'h0000_03E7);
        send_poll(1'b0, 1'b0, 32'h0000_0400);
        // time going backwards
        send_poll(1'b1, 1'b0, 32'd2000);
        send_poll(1'b1, 1'b0, 32'd1500);
        send_poll(1'b0, 1'b0, 32'd0);

        // random phases over several register settings
        clock_ms = 32'd6000;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    hold   = 16'd1;
                    period = 16'd1;
                end
                1: begin
                    hold   = 16'hFFFF;
                    period = 16'hFFFF;
                end
                2: begin
                    hold   = 16'd0;
                    period = 16'd0;
                end
                3: begin
                    hold   = 16'hFFFF;
                    period = 16'd1;
                end
                4: begin
                    hold   = 16'd1;
                    period = 16'hFFFF;
                end
                default: begin
                    hold   = 16'($urandom_range(5, 300));
                    period = 16'($urandom_range(2, 80));
                end
            endcase
            write_reg(tilpf_pkg::CFG_LONG_PRESS, hold);
            write_reg(tilpf_pkg::CFG_BLINK_PERIOD, period);
            if (p == 6) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1500);
            end
            if (p == 7) begin
                calm = 1'b1;
            end
            run_traffic((p == 2) ? 40 : 95,
                        int'(((hold > period) ? hold : period) / 6) + 1);
        end

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[turn_indicator_long_press_flasher.f]
hw/rtl/tilpf_pkg.sv
hw/rtl/tilpf_step.sv
hw/rtl/turn_indicator_long_press_flasher.sv
sim/turn_indicator_long_press_flasher_tb.sv
